// ===== rtl/core/ftl_pkg.sv =====
// shared constants, types and field layouts for the trilinear field-map lookup core
// no dependencies; used by ftl_lerp and the top level by scoped names
package ftl_pkg;

    // grid store
    localparam int MAX_POINTS = 32768;
    localparam int ADDR_W     = $clog2(MAX_POINTS);
    localparam int BASE_W     = 25;

    // fixed-point formats
    localparam int COORD_W   = 24;
    localparam int LOCAL_W   = COORD_W + 1;
    localparam int STEP_W    = 24;
    localparam int PROD_W    = COORD_W + STEP_W;
    localparam int PROD_FRAC = 24;
    localparam int FRAC_BITS = 16;
    localparam int VAL_W     = 32;
    localparam int DIM_W     = 8;
    localparam int STRIDE_W  = 2 * DIM_W;
    localparam int WORD_W    = 3 * VAL_W;
    localparam int IDX_W     = 15;

    // stream layouts
    localparam int S_TDATA_W = 184;
    localparam int M_TDATA_W = 96;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 24;

    // pipeline depth, stage 1 takes the transfer and the last stage feeds the output
    localparam int NSTAGE = 12;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ORIGIN_X   = 3'd0,
        REG_ORIGIN_Y   = 3'd1,
        REG_ORIGIN_Z   = 3'd2,
        REG_INV_STEP_X = 3'd3,
        REG_INV_STEP_Y = 3'd4,
        REG_INV_STEP_Z = 3'd5,
        REG_GRID_DIMS  = 3'd6
    } t_cfg_reg;

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_QUERY = 1'b1
    } t_op;

    localparam logic [CFG_W-1:0] INV_STEP_RST  = 24'd65536;
    localparam logic [CFG_W-1:0] GRID_DIMS_RST = 24'd131586;

    // write item carried down to the store stage
    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic [WORD_W-1:0] word;
    } t_wr;

endpackage

// ===== rtl/core/ftl_ram.sv =====
// generic single-write, dual-read memory with registered read data
// no dependencies
module ftl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr0,
    input  logic [$clog2(DEPTH)-1:0] i_raddr1,
    output logic [WIDTH-1:0]         o_rdata0,
    output logic [WIDTH-1:0]         o_rdata1
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // two registered read ports
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata0 <= r_mem[i_raddr0];
            o_rdata1 <= r_mem[i_raddr1];
        end
    end

endmodule

// ===== rtl/core/ftl_lerp.sv =====
// one linear blend step a + floor((b - a) * f / 2^FRAC_BITS), two register stages
// depends on ftl_pkg
module ftl_lerp (
    input  logic                                 i_clk,
    input  logic                                 i_en_mul,
    input  logic                                 i_en_add,
    input  logic signed [ftl_pkg::VAL_W-1:0]     i_a,
    input  logic signed [ftl_pkg::VAL_W-1:0]     i_b,
    input  logic [ftl_pkg::FRAC_BITS-1:0]        i_f,
    output logic signed [ftl_pkg::VAL_W-1:0]     o_r
);

    localparam int DIFF_W = ftl_pkg::VAL_W + 1;
    localparam int P_W    = DIFF_W + ftl_pkg::FRAC_BITS + 1;
    localparam int Q_W    = P_W - ftl_pkg::FRAC_BITS;

    logic signed [DIFF_W-1:0]           n_diff;
    logic signed [P_W-1:0]              r_p;
    logic signed [ftl_pkg::VAL_W-1:0]   r_a;
    logic signed [Q_W-1:0]              n_q;
    logic signed [Q_W-1:0]              n_sum;

    assign n_diff = DIFF_W'(i_b) - DIFF_W'(i_a);

    // difference times fraction
    always_ff @(posedge i_clk) begin
        if (i_en_mul) begin
            r_a <= i_a;
            r_p <= P_W'(n_diff) * P_W'($signed({1'b0, i_f}));
        end
    end

    // arithmetic shift floors both signs, result stays between a and b
    assign n_q   = Q_W'(r_p >>> ftl_pkg::FRAC_BITS);
    assign n_sum = Q_W'(r_a) + n_q;

    always_ff @(posedge i_clk) begin
        if (i_en_add) begin
            o_r <= n_sum[ftl_pkg::VAL_W-1:0];
        end
    end

endmodule

// ===== rtl/core/field_map_trilinear_lookup_core.sv =====
// top level of the trilinear field-map lookup: config registers, pipeline and grid store
// depends on ftl_pkg, ftl_ram and ftl_lerp
//
// Twelve-stage pipeline that takes one transfer per clock while the output is not held
// and keeps that rate under any mix of grid writes and queries. A grid write gives no
// result and lands in the store as it leaves stage 5, so any later query sees it.
// Stages: origin subtract, per-axis step multiply, cell split and inside test, base
// address, eight corner addresses, store read, then two stages each for the x, y and z
// blends. The eight corners come from four copies of the store, each with two read
// ports; every grid write goes to all four. Ready runs back through the stages in the
// same cycle and an empty stage lets the stages behind it move, so the input keeps
// taking transfers while a result waits as long as an earlier stage is empty. Grid
// entries are undefined until written, and config is to be changed only while idle;
// the block itself does not enforce this.
module field_map_trilinear_lookup_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // config write channel
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [ftl_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [ftl_pkg::CFG_W-1:0]          i_cfg_data,
    // input stream
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // coord_x[23:0] coord_y[47:24] coord_z[71:48] entry_index[86:72]
    // value_x[118:87] value_y[150:119] value_z[182:151], bit 183 zero
    input  logic [ftl_pkg::S_TDATA_W-1:0]      s_axis_tdata,
    // op[0]
    input  logic                               s_axis_tuser,
    // output stream
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // field_x[31:0] field_y[63:32] field_z[95:64]
    output logic [ftl_pkg::M_TDATA_W-1:0]      m_axis_tdata,
    // inside_res[0]
    output logic                               m_axis_tuser
);

    localparam int NS  = ftl_pkg::NSTAGE;
    localparam int CW  = ftl_pkg::COORD_W;
    localparam int LW  = ftl_pkg::LOCAL_W;
    localparam int PW  = ftl_pkg::PROD_W;
    localparam int PF  = ftl_pkg::PROD_FRAC;
    localparam int FB  = ftl_pkg::FRAC_BITS;
    localparam int DW  = ftl_pkg::DIM_W;
    localparam int SW  = ftl_pkg::STRIDE_W;
    localparam int BW  = ftl_pkg::BASE_W;
    localparam int AW  = ftl_pkg::ADDR_W;
    localparam int VW  = ftl_pkg::VAL_W;
    localparam int WW  = ftl_pkg::WORD_W;
    localparam int CELL_W = PW - PF;

    // config registers
    logic signed [CW-1:0]        r_origin [3];
    logic [ftl_pkg::STEP_W-1:0]  r_inv [3];
    logic [ftl_pkg::CFG_W-1:0]   r_dims;
    logic [SW-1:0]               r_sx;
    logic [DW-1:0]               n_dim [3];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin[0] <= '0;
            r_origin[1] <= '0;
            r_origin[2] <= '0;
            r_inv[0]    <= ftl_pkg::INV_STEP_RST;
            r_inv[1]    <= ftl_pkg::INV_STEP_RST;
            r_inv[2]    <= ftl_pkg::INV_STEP_RST;
            r_dims      <= ftl_pkg::GRID_DIMS_RST;
        end else if (i_cfg_valid) begin
            case (ftl_pkg::t_cfg_reg'(i_cfg_index))
                ftl_pkg::REG_ORIGIN_X:   r_origin[0] <= i_cfg_data;
                ftl_pkg::REG_ORIGIN_Y:   r_origin[1] <= i_cfg_data;
                ftl_pkg::REG_ORIGIN_Z:   r_origin[2] <= i_cfg_data;
                ftl_pkg::REG_INV_STEP_X: r_inv[0]    <= i_cfg_data;
                ftl_pkg::REG_INV_STEP_Y: r_inv[1]    <= i_cfg_data;
                ftl_pkg::REG_INV_STEP_Z: r_inv[2]    <= i_cfg_data;
                ftl_pkg::REG_GRID_DIMS:  r_dims      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign n_dim[0] = r_dims[DW-1:0];
    assign n_dim[1] = r_dims[2*DW-1:DW];
    assign n_dim[2] = r_dims[3*DW-1:2*DW];

    // x stride ny*nz; config is to be kept quiet while items are in flight, not enforced here
    always_ff @(posedge i_clk) begin
        r_sx <= SW'(n_dim[1]) * SW'(n_dim[2]);
    end

    // stage valids and per-stage advance
    logic [NS:1] r_v;
    logic [NS:1] en;

    always_comb begin
        en[NS] = !r_v[NS] || m_axis_tready;
        for (int k = NS - 1; k >= 1; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    assign s_axis_tready = en[1];

    // unpack input
    logic signed [CW-1:0] n_coord [3];
    ftl_pkg::t_wr         n_wr;

    assign n_coord[0] = s_axis_tdata[CW-1:0];
    assign n_coord[1] = s_axis_tdata[2*CW-1:CW];
    assign n_coord[2] = s_axis_tdata[3*CW-1:2*CW];
    assign n_wr.idx   = s_axis_tdata[3*CW +: ftl_pkg::IDX_W];
    assign n_wr.word  = s_axis_tdata[3*CW + ftl_pkg::IDX_W +: WW];

    // op and write payload travel to the store stage
    logic         r_op [1:5];
    ftl_pkg::t_wr r_wr [1:5];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int k = 1; k <= NS; k++) begin
                if (en[k]) begin
                    if (k == 1) begin
                        r_v[k] <= s_axis_tvalid;
                    end else if (k == 6) begin
                        r_v[k] <= r_v[5] && (r_op[5] == ftl_pkg::OP_QUERY);
                    end else begin
                        r_v[k] <= r_v[k-1];
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r_op[1] <= s_axis_tuser;
            r_wr[1] <= n_wr;
        end
        for (int k = 2; k <= 5; k++) begin
            if (en[k]) begin
                r_op[k] <= r_op[k-1];
                r_wr[k] <= r_wr[k-1];
            end
        end
    end

    // stage 1: subtract origin
    logic signed [LW-1:0] r_local [3];

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            for (int a = 0; a < 3; a++) begin
                r_local[a] <= LW'(n_coord[a]) - LW'(r_origin[a]);
            end
        end
    end

    // stage 2: scale by reciprocal step
    logic          r_neg  [3];
    logic [PW-1:0] r_prod [3];

    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            for (int a = 0; a < 3; a++) begin
                r_neg[a]  <= r_local[a][LW-1];
                r_prod[a] <= PW'(r_local[a][CW-1:0]) * PW'(r_inv[a]);
            end
        end
    end

    // stage 3: split cell and fraction, inside test
    logic [DW-1:0]     r_cell [3];
    logic [FB-1:0]     r_frac3 [3];
    logic              r_in3;
    logic [2:0]        n_ok;
    logic [CELL_W-1:0] n_cell [3];
    logic [DW-1:0]     n_lim [3];

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            n_cell[a] = r_prod[a][PW-1:PF];
            n_lim[a]  = n_dim[a] - DW'(2);
            n_ok[a]   = !r_neg[a] && (n_dim[a] >= DW'(2))
                        && (n_cell[a] <= CELL_W'(n_lim[a]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[3]) begin
            for (int a = 0; a < 3; a++) begin
                r_cell[a]  <= n_cell[a][DW-1:0];
                r_frac3[a] <= r_prod[a][PF-1 -: FB];
            end
            r_in3 <= &n_ok;
        end
    end

    // stage 4: linear base address
    logic [BW-1:0] r_base;
    logic [FB-1:0] r_frac4 [3];
    logic          r_in4;

    always_ff @(posedge i_clk) begin
        if (en[4]) begin
            r_base  <= BW'(r_cell[0]) * BW'(r_sx) + BW'(r_cell[1]) * BW'(n_dim[2])
                       + BW'(r_cell[2]);
            r_frac4 <= r_frac3;
            r_in4   <= r_in3;
        end
    end

    // stage 5: eight corner addresses, corner number is i*4 + j*2 + k
    logic [AW-1:0] r_addr [8];
    logic [7:0]    r_oor5;
    logic [FB-1:0] r_frac5 [3];
    logic          r_in5;
    logic [BW-1:0] n_caddr [8];

    always_comb begin
        for (int c = 0; c < 8; c++) begin
            n_caddr[c] = r_base + (c[2] ? BW'(r_sx) : BW'(0))
                         + (c[1] ? BW'(n_dim[2]) : BW'(0)) + BW'(c[0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[5]) begin
            for (int c = 0; c < 8; c++) begin
                r_addr[c] <= n_caddr[c][AW-1:0];
                r_oor5[c] <= |n_caddr[c][BW-1:AW];
            end
            r_frac5 <= r_frac4;
            r_in5   <= r_in4;
        end
    end

    // stage 6: grid store, four copies for eight reads; writes land here in order
    logic          n_we;
    logic [WW-1:0] n_rd [8];
    logic [7:0]    r_oor6;
    logic [FB-1:0] r_frac6 [3];
    logic          r_in6;

    assign n_we = en[6] && r_v[5] && (r_op[5] == ftl_pkg::OP_WRITE);

    for (genvar m = 0; m < 4; m++) begin : g_bank
        ftl_ram #(
            .WIDTH (WW),
            .DEPTH (ftl_pkg::MAX_POINTS)
        ) u_ram (
            .i_clk    (i_clk),
            .i_we     (n_we),
            .i_waddr  (r_wr[5].idx[AW-1:0]),
            .i_wdata  (r_wr[5].word),
            .i_re     (en[6]),
            .i_raddr0 (r_addr[2*m]),
            .i_raddr1 (r_addr[2*m+1]),
            .o_rdata0 (n_rd[2*m]),
            .o_rdata1 (n_rd[2*m+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (en[6]) begin
            r_oor6  <= r_oor5;
            r_frac6 <= r_frac5;
            r_in6   <= r_in5;
        end
    end

    // corners beyond the store read as zero
    logic signed [VW-1:0] n_corner [3][8];

    always_comb begin
        for (int c = 0; c < 8; c++) begin
            for (int q = 0; q < 3; q++) begin
                n_corner[q][c] = r_oor6[c] ? '0 : n_rd[c][q*VW +: VW];
            end
        end
    end

    // fractions and inside flag follow the blend stages
    logic [FB-1:0] r_fy [7:8];
    logic [FB-1:0] r_fz [7:10];
    logic          r_in [7:12];

    always_ff @(posedge i_clk) begin
        if (en[7]) begin
            r_fy[7] <= r_frac6[1];
            r_fz[7] <= r_frac6[2];
            r_in[7] <= r_in6;
        end
        if (en[8]) begin
            r_fy[8] <= r_fy[7];
            r_fz[8] <= r_fz[7];
        end
        for (int k = 9; k <= 10; k++) begin
            if (en[k]) begin
                r_fz[k] <= r_fz[k-1];
            end
        end
        for (int k = 8; k <= 12; k++) begin
            if (en[k]) begin
                r_in[k] <= r_in[k-1];
            end
        end
    end

    // stages 7 to 12: blend along x, then y, then z
    logic signed [VW-1:0] n_bx [3][4];
    logic signed [VW-1:0] n_hy [3][2];
    logic signed [VW-1:0] n_res [3];

    for (genvar q = 0; q < 3; q++) begin : g_comp
        for (genvar p = 0; p < 4; p++) begin : g_x
            ftl_lerp u_lerp (
                .i_clk    (i_clk),
                .i_en_mul (en[7]),
                .i_en_add (en[8]),
                .i_a      (n_corner[q][p]),
                .i_b      (n_corner[q][4+p]),
                .i_f      (r_frac6[0]),
                .o_r      (n_bx[q][p])
            );
        end
        for (genvar p = 0; p < 2; p++) begin : g_y
            ftl_lerp u_lerp (
                .i_clk    (i_clk),
                .i_en_mul (en[9]),
                .i_en_add (en[10]),
                .i_a      (n_bx[q][p]),
                .i_b      (n_bx[q][2+p]),
                .i_f      (r_fy[8]),
                .o_r      (n_hy[q][p])
            );
        end
        ftl_lerp u_lerp_z (
            .i_clk    (i_clk),
            .i_en_mul (en[11]),
            .i_en_add (en[12]),
            .i_a      (n_hy[q][0]),
            .i_b      (n_hy[q][1]),
            .i_f      (r_fz[10]),
            .o_r      (n_res[q])
        );
    end

    // output, zero when outside the grid
    assign m_axis_tvalid = r_v[NS];
    assign m_axis_tuser  = r_in[12];
    assign m_axis_tdata  = r_in[12] ? {n_res[2], n_res[1], n_res[0]} : '0;

endmodule
